// ===== hw/rtl/lfia_pkg.sv =====
// lfia_pkg: shared constants, datapath op codes and status struct for the
// lowest free index allocator. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lfia_pkg;

  localparam int POOL_SIZE = 1024;
  localparam int IDX_W     = 10;
  localparam int ADDR_W    = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);
  localparam int DATA_W    = 16;
  localparam int POS_W     = ADDR_W + 2;

  localparam logic       CMD_FREE     = 1'b1;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_FRESH,
    OP_EXHAUST,
    OP_OVERFLOW,
    OP_PUSH_INIT,
    OP_RD_PARENT,
    OP_PARENT_STEP,
    OP_WRITE_VAL,
    OP_RD_ROOT,
    OP_RD_LAST,
    OP_GET_LAST,
    OP_RD_LEFT,
    OP_RD_RIGHT,
    OP_CHILD_STEP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic cmd_free;
    logic heap_empty;
    logic heap_full;
    logic fresh_left;
    logic pos_zero;
    logic left_out;
    logic parent_le_val;
    logic val_le_child;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfia_ram.sv =====
// lfia_ram: generic single write port, single read port ram with registered
// read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lfia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lfia_dp.sv =====
// lfia_dp: datapath of the allocator: heap ram, heap count, fresh counter,
// sift registers and output payload. Uses lfia_pkg and lfia_ram.
`timescale 1ns / 1ps
`default_nettype none

module lfia_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lfia_pkg::dp_op_t              op,
  input  wire logic                          req_cmd,
  input  wire logic [lfia_pkg::IDX_W-1:0]    req_index,
  output lfia_pkg::dp_status_t               stat,
  output logic      [lfia_pkg::IDX_W-1:0]    out_index,
  output logic      [1:0]                    out_status
);
  import lfia_pkg::*;

  logic              cmd_reg;
  logic [IDX_W-1:0]  idx_reg;
  logic [CNT_W-1:0]  heap_count;
  logic [CNT_W-1:0]  next_fresh;
  logic [ADDR_W-1:0] pos;
  logic [IDX_W-1:0]  val;
  logic [IDX_W-1:0]  left_val;
  logic [IDX_W-1:0]  res_index;
  logic [1:0]        res_status;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [IDX_W-1:0]  wdata;
  logic [ADDR_W-1:0] raddr;
  logic [IDX_W-1:0]  rdata;

  logic [ADDR_W-1:0] up_pos;
  logic [POS_W-1:0]  left_pos;
  logic [POS_W-1:0]  right_pos;
  logic [POS_W-1:0]  count_ext;
  logic              right_in;
  logic              take_right;
  logic [IDX_W-1:0]  child_val;
  logic [ADDR_W-1:0] child_pos;

  lfia_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_SIZE)
  ) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign up_pos    = ADDR_W'((pos - ADDR_W'(1)) >> 1);
  assign left_pos  = {1'b0, pos, 1'b1};
  assign right_pos = left_pos + POS_W'(1);
  assign count_ext = POS_W'(heap_count);
  assign right_in  = right_pos < count_ext;
  // on equal children the right one wins
  assign take_right = right_in && !(left_val < rdata);
  assign child_val  = take_right ? rdata : left_val;
  assign child_pos  = take_right ? right_pos[ADDR_W-1:0] : left_pos[ADDR_W-1:0];

  always_comb begin
    stat.cmd_free      = (cmd_reg == CMD_FREE);
    stat.heap_empty    = (heap_count == '0);
    stat.heap_full     = (heap_count == CNT_W'(POOL_SIZE));
    stat.fresh_left    = (next_fresh < CNT_W'(POOL_SIZE));
    stat.pos_zero      = (pos == '0);
    stat.left_out      = (left_pos >= count_ext);
    stat.parent_le_val = (rdata <= val);
    stat.val_le_child  = (val <= child_val);
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = val;
    raddr = '0;
    case (op)
      OP_RD_PARENT: raddr = up_pos;
      OP_PARENT_STEP: begin
        we = 1'b1;
        if (!stat.parent_le_val) begin
          wdata = rdata;
        end
      end
      OP_WRITE_VAL: we = 1'b1;
      OP_RD_ROOT:   raddr = '0;
      OP_RD_LAST:   raddr = heap_count[ADDR_W-1:0];
      OP_RD_LEFT:   raddr = left_pos[ADDR_W-1:0];
      OP_RD_RIGHT:  raddr = right_pos[ADDR_W-1:0];
      OP_CHILD_STEP: begin
        we = 1'b1;
        if (!stat.val_le_child) begin
          wdata = child_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_count <= '0;
      next_fresh <= '0;
    end else begin
      case (op)
        OP_FRESH:     next_fresh <= next_fresh + CNT_W'(1);
        OP_PUSH_INIT: heap_count <= heap_count + CNT_W'(1);
        OP_RD_ROOT:   heap_count <= heap_count - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd_reg <= req_cmd;
        idx_reg <= req_index;
      end
      OP_FRESH: begin
        res_index  <= IDX_W'(next_fresh);
        res_status <= ST_OK;
      end
      OP_EXHAUST: begin
        res_index  <= '0;
        res_status <= ST_EXHAUSTED;
      end
      OP_OVERFLOW: begin
        res_index  <= '0;
        res_status <= ST_OVERFLOW;
      end
      OP_PUSH_INIT: begin
        pos        <= heap_count[ADDR_W-1:0];
        val        <= idx_reg;
        res_index  <= '0;
        res_status <= ST_OK;
      end
      OP_PARENT_STEP: begin
        if (!stat.parent_le_val) begin
          pos <= up_pos;
        end
      end
      OP_RD_LAST: begin
        res_index  <= rdata;
        res_status <= ST_OK;
        pos        <= '0;
      end
      OP_GET_LAST: val <= rdata;
      OP_RD_RIGHT: left_val <= rdata;
      OP_CHILD_STEP: begin
        if (!stat.val_le_child) begin
          pos <= child_pos;
        end
      end
      OP_EMIT: begin
        out_index  <= res_index;
        out_status <= res_status;
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    heap_count <= CNT_W'(POOL_SIZE))
    else $error("heap count above pool size");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    next_fresh <= CNT_W'(POOL_SIZE))
    else $error("fresh counter above pool size");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    op == OP_RD_ROOT |-> heap_count != '0)
    else $error("pop from empty heap");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    op == OP_PUSH_INIT |-> heap_count != CNT_W'(POOL_SIZE))
    else $error("push into full heap");

  a_fresh_avail: assert property (@(posedge clk) disable iff (rst)
    op == OP_FRESH |-> next_fresh < CNT_W'(POOL_SIZE))
    else $error("fresh index handed out past pool size");

endmodule

`default_nettype wire

// ===== hw/rtl/lfia_ctrl.sv =====
// lfia_ctrl: controller state machine of the allocator; sequences sift-up
// and sift-down steps and the output handshake. Uses lfia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfia_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  input  wire lfia_pkg::dp_status_t stat,
  output lfia_pkg::dp_op_t          op
);
  import lfia_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_CHECK,
    S_UP_STEP,
    S_POP_LAST,
    S_POP_GETLAST,
    S_DOWN_CHECK,
    S_DOWN_RIGHT,
    S_DOWN_STEP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit;

  assign s_tready = (state == S_IDLE);
  assign emit     = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    op         = OP_NOP;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op         = OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.cmd_free) begin
          if (stat.heap_full) begin
            op         = OP_OVERFLOW;
            state_next = S_DONE;
          end else begin
            op         = OP_PUSH_INIT;
            state_next = S_UP_CHECK;
          end
        end else if (!stat.heap_empty) begin
          op         = OP_RD_ROOT;
          state_next = S_POP_LAST;
        end else if (stat.fresh_left) begin
          op         = OP_FRESH;
          state_next = S_DONE;
        end else begin
          op         = OP_EXHAUST;
          state_next = S_DONE;
        end
      end
      S_UP_CHECK: begin
        if (stat.pos_zero) begin
          op         = OP_WRITE_VAL;
          state_next = S_DONE;
        end else begin
          op         = OP_RD_PARENT;
          state_next = S_UP_STEP;
        end
      end
      S_UP_STEP: begin
        op         = OP_PARENT_STEP;
        state_next = stat.parent_le_val ? S_DONE : S_UP_CHECK;
      end
      S_POP_LAST: begin
        op         = OP_RD_LAST;
        state_next = S_POP_GETLAST;
      end
      S_POP_GETLAST: begin
        op         = OP_GET_LAST;
        state_next = S_DOWN_CHECK;
      end
      S_DOWN_CHECK: begin
        if (stat.left_out) begin
          op         = OP_WRITE_VAL;
          state_next = S_DONE;
        end else begin
          op         = OP_RD_LEFT;
          state_next = S_DOWN_RIGHT;
        end
      end
      S_DOWN_RIGHT: begin
        op         = OP_RD_RIGHT;
        state_next = S_DOWN_STEP;
      end
      S_DOWN_STEP: begin
        op         = OP_CHILD_STEP;
        state_next = stat.val_le_child ? S_DONE : S_DOWN_CHECK;
      end
      S_DONE: begin
        if (emit) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_DECIDE)
    else $error("accepted request did not start processing");

  a_no_emit_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> op != OP_EMIT)
    else $error("result overwritten while still pending");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    op == OP_EMIT |=> state == S_IDLE && m_tvalid)
    else $error("emit did not present a result");

endmodule

`default_nettype wire

// ===== hw/rtl/lowest_free_index_allocator.sv =====
// lowest_free_index_allocator: one request in, one result out.
// fresh, exhausted and overflow results need no heap access; a free
// sifts up through the heap and an allocate from the heap sifts down,
// each level's reads sequenced over the single read port of the heap
// ram. one request at a time.
// reset: synchronous; heap and fresh counter start empty, ram is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_index_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [lfia_pkg::DATA_W-1:0]  s_tdata,  // [9:0] index_in, rest zero
  input  wire logic                         s_tuser,  // [0] command
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [lfia_pkg::DATA_W-1:0]  m_tdata,  // [9:0] index_out, rest zero
  output logic      [1:0]                   m_tuser   // [1:0] status
);
  import lfia_pkg::*;

  dp_op_t           op;
  dp_status_t       stat;
  logic [IDX_W-1:0] out_index;

  lfia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .op       (op)
  );

  lfia_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .req_cmd    (s_tuser),
    .req_index  (s_tdata[IDX_W-1:0]),
    .stat       (stat),
    .out_index  (out_index),
    .out_status (m_tuser)
  );

  assign m_tdata = DATA_W'(out_index);

endmodule

`default_nettype wire

// ===== test/lowest_free_index_allocator_tb.sv =====
// lowest_free_index_allocator_tb: self-checking bench for the free index allocator.
// Walks a table of requests, then random bursts, with a behavioral min-heap
// predictor. Depends on lfia_pkg and the lowest_free_index_allocator rtl.
`timescale 1ns / 1ps

module lowest_free_index_allocator_tb;
  import lfia_pkg::*;

  localparam logic CMD_ALLOC = 1'b0;
  localparam int   N_RANDOM  = 5;
  localparam int   N_ROWS    = 18;
  localparam int   MAX_SHOWN = 10;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [1:0]       status;
  } grant_t;

  typedef struct {
    logic             cmd;
    logic [IDX_W-1:0] idx;
    int               reps;
    bit               rnd_idx;
    bit               typed;
    grant_t           want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [1:0]        m_tuser;

  // shadow of the allocator state
  logic [IDX_W-1:0] free_heap [POOL_SIZE];
  int               heap_count = 0;
  int               next_fresh = 0;

  grant_t           pending_grants [$];
  logic [IDX_W-1:0] handed_out [$];
  plan_row_t        plan [N_ROWS];

  int errors = 0;
  int sent_total = 0;
  int planned_total = 0;
  int checked = 0;
  int exhausted_seen = 0;
  int dropped_seen = 0;
  int send_idle_pct = 11;
  int recv_idle_pct = 83;

  lowest_free_index_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [9:0] index_in, rest zero
    .s_tuser  (s_tuser),   // [0] command
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [9:0] index_out, rest zero
    .m_tuser  (m_tuser)    // [1:0] status
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void swap_heap(input int a, input int b);
    logic [IDX_W-1:0] t;
    t = free_heap[a];
    free_heap[a] = free_heap[b];
    free_heap[b] = t;
  endfunction

  function automatic grant_t predict_grant(input logic cmd, input logic [IDX_W-1:0] idx);
    grant_t r;
    int     pos;
    int     up;
    int     l;
    int     c;
    r.index = '0;
    r.status = ST_OK;
    if (cmd == CMD_FREE) begin
      if (heap_count >= POOL_SIZE) begin
        r.status = ST_OVERFLOW;
      end else begin
        pos = heap_count;
        free_heap[pos] = idx;
        heap_count++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (free_heap[up] <= free_heap[pos]) break;
          swap_heap(up, pos);
          pos = up;
        end
      end
    end else if (heap_count > 0) begin
      r.index = free_heap[0];
      heap_count--;
      free_heap[0] = free_heap[heap_count];
      pos = 0;
      while (1) begin
        l = 2 * pos + 1;
        if (l >= heap_count) break;
        c = l;
        // equal children: right one wins
        if (l + 1 < heap_count && !(free_heap[l] < free_heap[l + 1])) c = l + 1;
        if (free_heap[pos] <= free_heap[c]) break;
        swap_heap(pos, c);
        pos = c;
      end
    end else if (next_fresh < POOL_SIZE) begin
      r.index = next_fresh[IDX_W-1:0];
      next_fresh++;
    end else begin
      r.status = ST_EXHAUSTED;
    end
    return r;
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= MAX_SHOWN) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx,
                              input bit typed, input grant_t typed_want);
    grant_t want;
    int     ph;
    ph = sent_total * 3 / planned_total;
    send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 83 : 0;
    recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 11 : 0;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= DATA_W'(idx);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_grant(cmd, idx);
    if (cmd == CMD_ALLOC && want.status == ST_OK) handed_out.push_back(want.index);
    if (want.status == ST_EXHAUSTED) exhausted_seen++;
    if (want.status == ST_OVERFLOW) dropped_seen++;
    pending_grants.push_back(typed ? typed_want : want);
    sent_total++;
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.index = m_tdata[IDX_W-1:0];
      got.status = m_tuser;
      if (pending_grants.size() == 0) begin
        flag_error($sformatf("result index %0d status %0d with no request pending",
                             got.index, got.status));
      end else begin
        want = pending_grants.pop_front();
        checked++;
        if (got.index != want.index)
          flag_error($sformatf("index_out expected %0d got %0d", want.index, got.index));
        if (got.status != want.status)
          flag_error($sformatf("status expected %0d got %0d", want.status, got.status));
      end
    end
  end

  initial begin
    int               r;
    int               k;
    int               j;
    int               burst;
    int               kind;
    int               rnd_sent;
    logic             cmd;
    logic [IDX_W-1:0] idx;

    plan = '{
      '{CMD_ALLOC, 10'd0,    1,    1'b0, 1'b1, '{10'd0,    ST_OK}},
      '{CMD_ALLOC, 10'd0,    1,    1'b0, 1'b1, '{10'd1,    ST_OK}},
      '{CMD_FREE,  10'd1023, 1,    1'b0, 1'b1, '{10'd0,    ST_OK}},
      '{CMD_FREE,  10'd0,    1,    1'b0, 1'b1, '{10'd0,    ST_OK}},
      // second free of the same index is stored again
      '{CMD_FREE,  10'd0,    1,    1'b0, 1'b1, '{10'd0,    ST_OK}},
      '{CMD_ALLOC, 10'd0,    1,    1'b0, 1'b1, '{10'd0,    ST_OK}},
      '{CMD_ALLOC, 10'd0,    1,    1'b0, 1'b1, '{10'd0,    ST_OK}},
      '{CMD_ALLOC, 10'd0,    1,    1'b0, 1'b1, '{10'd1023, ST_OK}},
      '{CMD_ALLOC, 10'd0,    1,    1'b0, 1'b1, '{10'd2,    ST_OK}},
      // duplicates give equal children on the way down
      '{CMD_FREE,  10'd5,    1,    1'b0, 1'b1, '{10'd0,    ST_OK}},
      '{CMD_FREE,  10'd5,    1,    1'b0, 1'b1, '{10'd0,    ST_OK}},
      '{CMD_FREE,  10'd3,    1,    1'b0, 1'b1, '{10'd0,    ST_OK}},
      '{CMD_FREE,  10'd7,    1,    1'b0, 1'b1, '{10'd0,    ST_OK}},
      '{CMD_FREE,  10'd3,    1,    1'b0, 1'b1, '{10'd0,    ST_OK}},
      '{CMD_ALLOC, 10'd0,    5,    1'b0, 1'b0, '{10'd0,    ST_OK}},
      // fill the heap with arbitrary indices, then one too many
      '{CMD_FREE,  10'd0,    1024, 1'b1, 1'b1, '{10'd0,    ST_OK}},
      '{CMD_FREE,  10'd1023, 1,    1'b0, 1'b1, '{10'd0,    ST_OVERFLOW}},
      '{CMD_ALLOC, 10'd0,    1,    1'b0, 1'b0, '{10'd0,    ST_OK}}
    };
    planned_total = N_RANDOM;
    for (r = 0; r < N_ROWS; r++) planned_total += plan[r].reps;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < N_ROWS; r++) begin
      for (k = 0; k < plan[r].reps; k++) begin
        idx = plan[r].rnd_idx ? IDX_W'($urandom) : plan[r].idx;
        send_request(plan[r].cmd, idx, plan[r].typed, plan[r].want);
      end
    end

    // bursts of allocates and of frees, mostly returning indices handed out earlier
    rnd_sent = 0;
    while (rnd_sent < N_RANDOM) begin
      kind = $urandom_range(99);
      burst = $urandom_range(1, 48);
      for (k = 0; k < burst && rnd_sent < N_RANDOM; k++) begin
        if (kind < 45) begin
          cmd = CMD_ALLOC;
          idx = IDX_W'($urandom);
        end else if (kind < 90) begin
          cmd = CMD_FREE;
          if (handed_out.size() > 0 && $urandom_range(9) < 8) begin
            j = $urandom_range(handed_out.size() - 1);
            idx = handed_out[j];
            handed_out.delete(j);
          end else begin
            idx = IDX_W'($urandom);
          end
        end else begin
          cmd = 1'($urandom_range(1));
          idx = IDX_W'($urandom);
        end
        send_request(cmd, idx, 1'b0, '0);
        rnd_sent++;
      end
    end
    s_tvalid <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (pending_grants.size() != 0) flag_error("requests left without a result");

    $display("ran %0d requests (%0d random), %0d results checked",
             sent_total, rnd_sent, checked);
    $display("pool exhausted %0d times, %0d frees dropped on a full heap, %0d mismatches",
             exhausted_seen, dropped_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
